/* sv/arena_bump_allocator_handle_table_unit_macros.svh */
// assertion helpers for the arena allocator unit
`ifndef ARENA_BUMP_ALLOCATOR_HANDLE_TABLE_UNIT_MACROS_SVH
`define ARENA_BUMP_ALLOCATOR_HANDLE_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ABAHT_ASSERT_IMPLIES(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define ABAHT_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define ABAHT_ASSERT_IMPLIES(name, clk, rst_n, cond, prop)
`define ABAHT_ASSERT_NEXT(name, clk, rst_n, cond, prop)

`endif

`endif

/* sv/abaht_pkg.sv */
`default_nettype none

package abaht_pkg;

    localparam int ARENA_BYTES_DEF = 65536;
    localparam int TABLE_SLOTS_DEF = 64;

    // allocations start on a 4-byte boundary
    localparam int ALIGN_LSB = 3;

    typedef enum logic [2:0] {
        ACT_ALLOC  = 3'd0,
        ACT_RESET  = 3'd1,
        ACT_ADD    = 3'd2,
        ACT_GET    = 3'd3,
        ACT_REMOVE = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOMEM     = 3'd1,
        ST_BADMARK   = 3'd2,
        ST_FULL      = 3'd3,
        ST_BADHANDLE = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] offset;
    } slot_entry_t;

    typedef struct packed {
        logic        en;
        slot_entry_t data;
    } slot_wr_t;

endpackage

`default_nettype wire

/* sv/abaht_slot_ram.sv */
`default_nettype none

module abaht_slot_ram
    import abaht_pkg::*;
#(
    parameter int DEPTH = TABLE_SLOTS_DEF,
    parameter int IDX_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output slot_entry_t           rd_data,
    input  wire slot_wr_t         wr,
    input  wire logic [IDX_W-1:0] wr_addr
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/arena_bump_allocator_handle_table_unit.sv */
// Bump arena allocator with a handle table. One request is worked on at a time; a
// finished result sits in an output register so the next request can be taken while
// it waits. Allocate, remove and every rejected request pass from the result registers
// through the done state to the output register; get first reads one slot table entry.
// Add and reset to marker walk the slot table one entry per cycle through its single
// read port: reset to marker walks the whole table, add stops at the first free slot
// and walks the whole table when the table is full. After reset the slot table is
// cleared one entry per cycle before the first request is taken.
`default_nettype none
`include "arena_bump_allocator_handle_table_unit_macros.svh"

module arena_bump_allocator_handle_table_unit
    import abaht_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [16:0] request_bytes,
    input  wire logic [16:0] marker,
    input  wire logic [6:0]  handle,
    input  wire logic [15:0] resource_offset,
    input  wire logic        resource_null,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [16:0]      result_offset,
    output logic [6:0]       result_handle
);

    localparam int PW    = $clog2(ARENA_BYTES + 1);
    localparam int SW    = ((PW > 17) ? PW : 17) + 2;
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int HW    = IDX_W + 8;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_GET   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             add_reg, add_next;
    logic [16:0]      mark_reg, mark_next;
    logic [15:0]      roff_reg, roff_next;
    status_t          res_status_reg, res_status_next;
    logic [16:0]      res_off_reg, res_off_next;
    logic [6:0]       res_handle_reg, res_handle_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [16:0]      out_off_reg, out_off_next;
    logic [6:0]       out_handle_reg, out_handle_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      rd_data;
    slot_wr_t         wr;
    logic [IDX_W-1:0] wr_addr;

    logic [SW-1:0]    aligned;
    logic [SW-1:0]    alloc_end;
    logic             nomem;
    logic             badmark;
    logic             handle_ok;
    logic [HW-1:0]    handle_m1;
    logic [HW-1:0]    found_handle;

    abaht_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .wr_addr (wr_addr)
    );

    assign aligned   = (SW'(ptr_reg) + SW'(ALIGN_LSB)) & ~SW'(ALIGN_LSB);
    assign alloc_end = aligned + SW'(request_bytes);
    assign nomem     = alloc_end > SW'(ARENA_BYTES);
    assign badmark   = SW'(marker) > SW'(ptr_reg);

    assign handle_ok    = (handle != '0) && (HW'(handle) <= HW'(TABLE_SLOTS));
    assign handle_m1    = HW'(handle) - HW'(1);
    assign found_handle = HW'(chk_idx_reg) + HW'(1);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        clr_next        = clr_reg;
        rd_next         = rd_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        add_next        = add_reg;
        mark_next       = mark_reg;
        roff_next       = roff_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_handle_next = out_handle_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr              = '0;
        wr_addr         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_off_next    = '0;
                    res_handle_next = '0;
                    state_next      = S_DONE;
                    case (action_t'(action))
                        ACT_ALLOC:
                        begin
                            if (nomem)
                            begin
                                res_status_next = ST_NOMEM;
                            end
                            else
                            begin
                                res_off_next = aligned[16:0];
                                ptr_next     = PW'(alloc_end);
                            end
                        end
                        ACT_RESET:
                        begin
                            if (badmark)
                            begin
                                res_status_next = ST_BADMARK;
                            end
                            else
                            begin
                                ptr_next     = PW'(marker);
                                mark_next    = marker;
                                add_next     = 1'b0;
                                rd_next      = '0;
                                chk_vld_next = 1'b0;
                                state_next   = S_SWEEP;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (resource_null)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                roff_next    = resource_offset;
                                add_next     = 1'b1;
                                rd_next      = '0;
                                chk_vld_next = 1'b0;
                                state_next   = S_SWEEP;
                            end
                        end
                        ACT_GET:
                        begin
                            if (!handle_ok)
                            begin
                                res_status_next = ST_BADHANDLE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = handle_m1[IDX_W-1:0];
                                state_next = S_GET;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!handle_ok)
                            begin
                                res_status_next = ST_BADHANDLE;
                            end
                            else
                            begin
                                wr.en   = 1'b1;
                                wr_addr = handle_m1[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // read slot rd_reg while checking the slot read in the previous cycle
                chk_vld_next = 1'b0;
                if (rd_reg != CNT_W'(TABLE_SLOTS))
                begin
                    rd_en        = 1'b1;
                    rd_addr      = rd_reg[IDX_W-1:0];
                    rd_next      = rd_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (add_reg)
                    begin
                        if (!rd_data.valid)
                        begin
                            wr.en            = 1'b1;
                            wr.data.valid    = 1'b1;
                            wr.data.offset   = roff_reg;
                            wr_addr          = chk_idx_reg;
                            res_status_next  = ST_OK;
                            res_handle_next  = found_handle[6:0];
                            state_next       = S_DONE;
                        end
                    end
                    else if (rd_data.valid && (17'(rd_data.offset) >= mark_reg))
                    begin
                        wr.en   = 1'b1;
                        wr_addr = chk_idx_reg;
                    end
                end
                else if (rd_reg == CNT_W'(TABLE_SLOTS))
                begin
                    res_status_next = add_reg ? ST_FULL : ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_GET:
            begin
                if (rd_data.valid)
                begin
                    res_off_next = 17'(rd_data.offset);
                end
                else
                begin
                    res_status_next = ST_EMPTY;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    out_handle_next = res_handle_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            clr_reg       <= '0;
            rd_reg        <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            clr_reg       <= clr_next;
            rd_reg        <= rd_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        add_reg        <= add_next;
        mark_reg       <= mark_next;
        roff_reg       <= roff_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
        out_handle_reg <= out_handle_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_offset = out_off_reg;
    assign result_handle = out_handle_reg;

    // pointer never runs past the arena
    `ABAHT_ASSERT_IMPLIES(a_ptr_in_arena, clk, rst_n, 1'b1, SW'(ptr_reg) <= SW'(ARENA_BYTES))
    // the sweep never writes the slot it is reading in the same cycle
    `ABAHT_ASSERT_IMPLIES(a_no_rw_same_slot, clk, rst_n, wr.en && rd_en, wr_addr != rd_addr)
    // a new result only comes from the done state
    `ABAHT_ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_DONE))
    // an accepted beat always moves the control out of idle
    `ABAHT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != S_IDLE)

endmodule

`default_nettype wire

/* dv/tb_arena_bump_allocator_handle_table_unit.sv */
`timescale 1ns / 1ps

module tb_arena_bump_allocator_handle_table_unit;
    import abaht_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD = 300;
    localparam int unsigned ALIGN_MASK = 3;
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [16:0] req_bytes;
        logic [16:0] mark;
        logic [6:0]  hdl;
        logic [15:0] res_off;
        logic        res_null;
        bit          wait_idle;
    } request_t;

    typedef struct {
        status_t     st;
        logic [16:0] off;
        logic [6:0]  hdl;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  action = '0;
    logic [16:0] request_bytes = '0;
    logic [16:0] marker = '0;
    logic [6:0]  handle = '0;
    logic [15:0] resource_offset = '0;
    logic        resource_null = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [16:0] result_offset;
    logic [6:0]  result_handle;

    request_t    request_queue[$];
    outcome_t    outcome_queue[$];
    request_t    cur_req;
    int          work_items = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    // predictor state
    int unsigned arena_top = 0;
    bit          slot_live [TABLE_SLOTS_DEF];
    logic [15:0] slot_addr [TABLE_SLOTS_DEF];

    // sender and receiver pacing
    int burst_left = 8;
    int gap_left = 0;
    int hold_left = 0;
    int beats_seen = 0;
    int rx_timer = 0;
    int rx_mode = 0;

    arena_bump_allocator_handle_table_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .request_bytes(request_bytes),
        .marker(marker),
        .handle(handle),
        .resource_offset(resource_offset),
        .resource_null(resource_null),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .result_offset(result_offset),
        .result_handle(result_handle)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t    o;
        int unsigned aligned;
        bit          placed;
        int          idx;
        o.st = ST_OK;
        o.off = '0;
        o.hdl = '0;
        case (r.act)
            ACT_ALLOC:
            begin
                aligned = (arena_top + ALIGN_MASK) & ~ALIGN_MASK;
                if (aligned + r.req_bytes > ARENA_BYTES_DEF)
                    o.st = ST_NOMEM;
                else
                begin
                    o.off = aligned[16:0];
                    arena_top = aligned + r.req_bytes;
                end
            end
            ACT_RESET:
            begin
                if (r.mark > arena_top)
                    o.st = ST_BADMARK;
                else
                begin
                    arena_top = 32'(r.mark);
                    for (int k = 0; k < TABLE_SLOTS_DEF; k++)
                        if (slot_live[k] && slot_addr[k] >= r.mark)
                            slot_live[k] = 1'b0;
                end
            end
            ACT_ADD:
            begin
                if (r.res_null)
                    o.st = ST_EMPTY;
                else
                begin
                    o.st = ST_FULL;
                    placed = 1'b0;
                    for (int k = 0; k < TABLE_SLOTS_DEF; k++)
                    begin
                        if (!placed && !slot_live[k])
                        begin
                            placed = 1'b1;
                            slot_live[k] = 1'b1;
                            slot_addr[k] = r.res_off;
                            o.hdl = 7'(k + 1);
                            o.st = ST_OK;
                        end
                    end
                end
            end
            ACT_GET, ACT_REMOVE:
            begin
                idx = int'(r.hdl) - 1;
                if (r.hdl == 0 || r.hdl > TABLE_SLOTS_DEF)
                    o.st = ST_BADHANDLE;
                else if (r.act == ACT_REMOVE)
                    slot_live[idx] = 1'b0;
                else if (!slot_live[idx])
                    o.st = ST_EMPTY;
                else
                    o.off = {1'b0, slot_addr[idx]};
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic int unsigned rand_bytes();
        return $urandom_range(0, 65536);
    endfunction

    function automatic int unsigned rand_handle();
        return $urandom_range(0, 127);
    endfunction

    function automatic int unsigned rand_roff();
        return $urandom_range(0, 65535);
    endfunction

    task automatic queue_req(input logic [2:0] act, input int unsigned nbytes,
                             input int unsigned mark, input int unsigned hdl,
                             input int unsigned roff, input bit rnull, input bit idle);
        request_t r;
        r.act = act;
        r.req_bytes = nbytes[16:0];
        r.mark = mark[16:0];
        r.hdl = hdl[6:0];
        r.res_off = roff[15:0];
        r.res_null = rnull;
        r.wait_idle = idle;
        request_queue.push_back(r);
        if (act <= ACT_REMOVE)
            work_items++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                outcome_queue.push_back(predict_outcome(cur_req));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0 &&
                         (!request_queue[0].wait_idle || outcome_queue.size() == 0))
                begin
                    cur_req = request_queue.pop_front();
                    action <= cur_req.act;
                    request_bytes <= cur_req.req_bytes;
                    marker <= cur_req.mark;
                    handle <= cur_req.hdl;
                    resource_offset <= cur_req.res_off;
                    resource_null <= cur_req.res_null;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk)
    begin
        outcome_t exp_o;
        bit       took;
        took = 1'b0;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                took = 1'b1;
                beats_seen++;
                if (outcome_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat, status %0d offset %0d handle %0d",
                             $time, status, result_offset, result_handle);
                    error_count++;
                end
                else
                begin
                    exp_o = outcome_queue.pop_front();
                    if (status !== exp_o.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_o.st, status);
                        error_count++;
                    end
                    if (result_offset !== exp_o.off)
                    begin
                        $display("%0t: result_offset expected %0d actual %0d",
                                 $time, exp_o.off, result_offset);
                        error_count++;
                    end
                    if (result_handle !== exp_o.hdl)
                    begin
                        $display("%0t: result_handle expected %0d actual %0d",
                                 $time, exp_o.hdl, result_handle);
                        error_count++;
                    end
                end
            end
            rx_timer++;
            if (rx_timer % 50 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (took && (beats_seen == 100 || beats_seen == 700))
            begin
                // long back-pressure so the input side fills up
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_timer % 5 != 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int  scen;
        int  n;
        int  sel;
        int  hdl;
        int  mark;
        int  nbytes;
        bit  idle;

        for (int k = 0; k < TABLE_SLOTS_DEF; k++)
        begin
            slot_live[k] = 1'b0;
            slot_addr[k] = '0;
        end

        // directed corners
        queue_req(ACT_ALLOC, 0, 65536, rand_handle(), rand_roff(), 1, 0);
        queue_req(ACT_ALLOC, 1, 0, 127, 65535, 0, 0);
        queue_req(ACT_ALLOC, 0, rand_bytes(), rand_handle(), rand_roff(), 1, 0);
        queue_req(ACT_ALLOC, 65536, rand_bytes(), rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_RESET, rand_bytes(), 65536, rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_GET, rand_bytes(), rand_bytes(), 0, rand_roff(), 1, 0);
        queue_req(ACT_GET, rand_bytes(), rand_bytes(), 127, rand_roff(), 0, 0);
        queue_req(ACT_REMOVE, rand_bytes(), rand_bytes(), 65, rand_roff(), 1, 0);
        queue_req(ACT_GET, rand_bytes(), rand_bytes(), 1, rand_roff(), 0, 0);
        queue_req(ACT_REMOVE, rand_bytes(), rand_bytes(), 1, rand_roff(), 0, 0);
        queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(), 1234, 1, 0);
        queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(), 65535, 0, 0);
        queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(), 0, 0, 0);
        queue_req(ACT_GET, rand_bytes(), rand_bytes(), 1, rand_roff(), 0, 0);
        queue_req(ACT_REMOVE, rand_bytes(), rand_bytes(), 1, rand_roff(), 0, 0);
        queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(), 3, 0, 0);
        queue_req(ACT_GET, rand_bytes(), rand_bytes(), 64, rand_roff(), 1, 0);
        queue_req(ACT_RESET, rand_bytes(), 0, rand_handle(), rand_roff(), 1, 0);
        queue_req(ACT_ALLOC, 65536, rand_bytes(), rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_ALLOC, 0, rand_bytes(), rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_ALLOC, 1, rand_bytes(), rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_RESET, rand_bytes(), 65536, rand_handle(), rand_roff(), 0, 0);
        queue_req(ACT_RESET, rand_bytes(), 1, rand_handle(), rand_roff(), 0, 0);
        for (int c = ACT_UNUSED_FIRST; c <= ACT_UNUSED_LAST; c++)
            queue_req(3'(c), rand_bytes(), rand_bytes(), rand_handle(), rand_roff(),
                      1'($urandom_range(0, 1)), 0);

        // random sequences; the first one starts from an idle block
        idle = 1'b1;
        n = work_items + RANDOM_ITEMS;
        while (work_items < n)
        begin
            scen = $urandom_range(0, 19);
            if (scen < 5)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    sel = $urandom_range(0, 15);
                    if (sel == 0)
                        nbytes = $urandom_range(0, 65536);
                    else if (sel < 3)
                        nbytes = $urandom_range(0, 16);
                    else
                        nbytes = $urandom_range(0, 1500);
                    queue_req(ACT_ALLOC, nbytes, rand_bytes(), rand_handle(), rand_roff(),
                              1'($urandom_range(0, 1)), idle);
                    idle = 1'b0;
                end
            end
            else if (scen < 9)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(),
                              ($urandom_range(0, 3) == 0) ? rand_roff()
                                                          : $urandom_range(0, 20000),
                              ($urandom_range(0, 11) == 0), idle);
                    idle = 1'b0;
                end
            end
            else if (scen < 13)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    sel = $urandom_range(0, 7);
                    if (sel == 0)
                        hdl = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
                    else if (sel < 5)
                        hdl = $urandom_range(1, 16);
                    else
                        hdl = $urandom_range(1, 64);
                    queue_req($urandom_range(0, 1) ? ACT_GET : ACT_REMOVE, rand_bytes(),
                              rand_bytes(), hdl, rand_roff(), 1'($urandom_range(0, 1)),
                              idle);
                    idle = 1'b0;
                end
            end
            else if (scen < 15)
            begin
                sel = $urandom_range(0, 5);
                if (sel == 0)
                    mark = 0;
                else if (sel == 1)
                    mark = $urandom_range(0, 65536);
                else
                    mark = $urandom_range(0, 12000);
                queue_req(ACT_RESET, rand_bytes(), mark, rand_handle(), rand_roff(),
                          1'($urandom_range(0, 1)), idle);
                idle = 1'b0;
            end
            else if (scen == 15 && $urandom_range(0, 3) == 0)
            begin
                // fill the table past full, then roll everything back
                repeat (TABLE_SLOTS_DEF + 2)
                begin
                    queue_req(ACT_ADD, rand_bytes(), rand_bytes(), rand_handle(),
                              rand_roff(), 0, idle);
                    idle = 1'b0;
                end
                queue_req(ACT_GET, rand_bytes(), rand_bytes(), 64, rand_roff(), 0, 0);
                queue_req(ACT_RESET, rand_bytes(), 0, rand_handle(), rand_roff(), 0, 0);
            end
            else if (scen == 16)
            begin
                // noise, including the unused action codes
                repeat ($urandom_range(1, 4))
                begin
                    queue_req(3'($urandom_range(0, 7)), rand_bytes(), rand_bytes(),
                              rand_handle(), rand_roff(), 1'($urandom_range(0, 1)), idle);
                    idle = 1'b0;
                end
            end
            else
            begin
                repeat ($urandom_range(2, 10))
                begin
                    queue_req(3'($urandom_range(ACT_ALLOC, ACT_REMOVE)),
                              $urandom_range(0, 800), $urandom_range(0, 4000),
                              $urandom_range(0, 70), $urandom_range(0, 4000),
                              ($urandom_range(0, 15) == 0), idle);
                    idle = 1'b0;
                end
            end
            if ($urandom_range(0, 24) == 0)
                idle = 1'b1;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid || outcome_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/abaht_pkg.sv
sv/abaht_slot_ram.sv
sv/arena_bump_allocator_handle_table_unit.sv
dv/tb_arena_bump_allocator_handle_table_unit.sv
